>>> src/gffl_pkg.sv
// Package for the flood-fill labeler: types, codes and default sizes.
package gffl_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_LABEL_BITS = 16;

   localparam int CSR_DATA_W = 9;
   localparam int COUNT_W    = 17;

   // Configuration register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ACT_WRITE_BARRIER = 3'd0,
      ACT_FILL          = 3'd1,
      ACT_READ          = 3'd2,
      ACT_FIND          = 3'd3,
      ACT_CLEAR         = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ_DATA,
      ST_WB_DATA,
      ST_SEED_DATA,
      ST_POP,
      ST_POP_DATA,
      ST_NB_ADDR,
      ST_NB_DATA,
      ST_FIND_ADDR,
      ST_FIND_DATA,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               status;
      logic               cell_colored;
      logic               cell_barrier;
      logic [15:0]        cell_label;
      logic               found;
      logic [7:0]         found_x;
      logic [7:0]         found_y;
      logic [COUNT_W-1:0] cells_filled;
   } rsp_type;

endpackage

>>> src/grid_flood_fill_labeler_core.sv
// Top level of the four-connected flood-fill labeler with its cell and stack memories.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| action, cell_x, cell_y, barrier_bit, fill_label
//  rsp     | out       | rsp_valid/rsp_stall| status, cell bits, label, found, x, y, count
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// Read and write barrier go through their data state to ST_RESP, which loads the result; a
// rejected coordinate goes straight there. Fill takes the seed, then per popped cell runs
// ST_POP, ST_POP_DATA, ST_NB_ADDR per direction, ST_NB_DATA per in-grid neighbour, and ST_POP
// again once the stack is empty, all bound by the single read port of the cell memory.
// Clear sweeps every cell-memory address, one per cycle, as reset does before the first
// request is taken. A request is taken while a result still waits on a stalled rsp channel.
module grid_flood_fill_labeler_core
   import gffl_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int LABEL_BITS = DEF_LABEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_action,
   input  logic [7:0]            req_cell_x,
   input  logic [7:0]            req_cell_y,
   input  logic                  req_barrier_bit,
   input  logic signed [15:0]    req_fill_label,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic                  rsp_cell_colored,
   output logic                  rsp_cell_barrier,
   output logic signed [15:0]    rsp_cell_label,
   output logic                  rsp_found,
   output logic [7:0]            rsp_found_x,
   output logic [7:0]            rsp_found_y,
   output logic [COUNT_W-1:0]    rsp_cells_filled,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int AW   = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int GWW  = $clog2(MAX_WIDTH + 1);
   localparam int GHW  = $clog2(MAX_HEIGHT + 1);
   localparam int XCW  = (XW + 1 > 9) ? XW + 1 : 9;
   localparam int YCW  = (YW + 1 > 9) ? YW + 1 : 9;
   localparam int WW   = LABEL_BITS + 2;
   localparam int EW   = (LABEL_BITS > 16) ? LABEL_BITS : 16;
   localparam int GW_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
   localparam int GH_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

   // Cell word: colored, barrier, label
   localparam int COL_BIT = LABEL_BITS + 1;
   localparam int BAR_BIT = LABEL_BITS;

   state_type             state_ff, state_in;
   logic [GWW-1:0]        gw_ff, gw_in;
   logic [GHW-1:0]        gh_ff, gh_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [YW-1:0]         y_ff, y_in;
   logic                  bar_ff, bar_in;
   logic [LABEL_BITS-1:0] lab_ff, lab_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [AW:0]           sp_ff, sp_in;
   logic [1:0]            dir_ff, dir_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   rsp_type               res_ff, res_in;
   rsp_type               out_ff, out_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  cell_we;
   logic [AW-1:0]         cell_waddr, cell_raddr;
   logic [WW-1:0]         cell_wdata, cell_rdata;
   logic                  stk_we;
   logic [AW-1:0]         stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic                  req_acc;
   logic                  req_inside;
   logic                  cell_open;
   logic [EW-1:0]         lab_ext_in, lab_ext_out;
   logic                  nb_ok;
   logic [XW-1:0]         nb_x;
   logic [YW-1:0]         nb_y;
   logic [XCW-1:0]        x_next_ext;
   logic [YCW-1:0]        y_next_ext;
   logic [COUNT_W-1:0]    cnt_inc;

   gffl_ram #(.WIDTH(WW), .DEPTH(CELLS)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   gffl_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // Handshake and bounds of the incoming coordinate
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign req_inside = (XCW'(req_cell_x) < XCW'(gw_ff)) && (YCW'(req_cell_y) < YCW'(gh_ff));

   // Label widening in both directions
   assign lab_ext_in  = EW'(req_fill_label);
   assign lab_ext_out = EW'(signed'(cell_rdata[LABEL_BITS-1:0]));

   assign cell_open = !cell_rdata[COL_BIT] && !cell_rdata[BAR_BIT];
   assign cnt_inc   = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_W'(1);

   // Neighbour of the current cell, order x-1, y-1, x+1, y+1
   assign x_next_ext = XCW'(x_ff) + XCW'(1);
   assign y_next_ext = YCW'(y_ff) + YCW'(1);
   always_comb begin
      nb_x  = x_ff;
      nb_y  = y_ff;
      nb_ok = 1'b0;
      case (dir_ff)
         2'd0: begin
            nb_x  = x_ff - XW'(1);
            nb_ok = (x_ff != '0);
         end
         2'd1: begin
            nb_y  = y_ff - YW'(1);
            nb_ok = (y_ff != '0);
         end
         2'd2: begin
            nb_x  = x_ff + XW'(1);
            nb_ok = (x_next_ext < XCW'(gw_ff));
         end
         2'd3: begin
            nb_y  = y_ff + YW'(1);
            nb_ok = (y_next_ext < YCW'(gh_ff));
         end
         default: nb_ok = 1'b0;
      endcase
   end

   // Sequencer: next state, memory accesses and result building
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      bar_in       = bar_ff;
      lab_in       = lab_ff;
      cnt_in       = cnt_ff;
      sp_in        = sp_ff;
      dir_in       = dir_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_we      = 1'b0;
      cell_waddr   = {x_ff, y_ff};
      cell_wdata   = {1'b1, cell_rdata[BAR_BIT], lab_ff};
      cell_raddr   = {x_ff, y_ff};
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[AW-1:0];
      stk_wdata    = {x_ff, y_ff};
      stk_raddr    = sp_ff[AW-1:0] - AW'(1);

      case (state_ff)
         ST_IDLE: begin
            x_in       = XW'(req_cell_x);
            y_in       = YW'(req_cell_y);
            cell_raddr = {XW'(req_cell_x), YW'(req_cell_y)};
            if (req_acc) begin
               res_in = '0;
               bar_in = req_barrier_bit;
               lab_in = lab_ext_in[LABEL_BITS-1:0];
               case (req_action)
                  ACT_WRITE_BARRIER, ACT_FILL, ACT_READ: begin
                     if (!req_inside) begin
                        res_in.status = 1'b1;
                        state_in      = ST_RESP;
                     end else if (req_action == ACT_WRITE_BARRIER) begin
                        state_in = ST_WB_DATA;
                     end else if (req_action == ACT_FILL) begin
                        state_in = ST_SEED_DATA;
                     end else begin
                        state_in = ST_READ_DATA;
                     end
                  end
                  ACT_FIND: begin
                     x_in     = '0;
                     y_in     = '0;
                     state_in = ST_FIND_ADDR;
                  end
                  ACT_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         // Sweep every cell back to uncoloured, no barrier
         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = '0;
            clr_in     = clr_ff + AW'(1);
            sp_in      = '0;
            if (clr_ff == '1) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end

         ST_READ_DATA: begin
            res_in.cell_colored = cell_rdata[COL_BIT];
            res_in.cell_barrier = cell_rdata[BAR_BIT];
            res_in.cell_label   = cell_rdata[COL_BIT] ? lab_ext_out[15:0] : 16'd0;
            state_in            = ST_RESP;
         end

         ST_WB_DATA: begin
            cell_we    = 1'b1;
            cell_wdata = {cell_rdata[COL_BIT], bar_ff, cell_rdata[LABEL_BITS-1:0]};
            state_in   = ST_RESP;
         end

         // Seed: take it if open, then work the stack
         ST_SEED_DATA: begin
            sp_in = '0;
            if (cell_open) begin
               cell_we   = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = '0;
               sp_in     = (AW + 1)'(1);
               cnt_in    = COUNT_W'(1);
               state_in  = ST_POP;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_POP: begin
            if (sp_ff == '0) begin
               res_in.cells_filled = cnt_ff;
               state_in            = ST_RESP;
            end else begin
               sp_in    = sp_ff - (AW + 1)'(1);
               state_in = ST_POP_DATA;
            end
         end

         ST_POP_DATA: begin
            x_in     = stk_rdata[AW-1:YW];
            y_in     = stk_rdata[YW-1:0];
            dir_in   = 2'd0;
            state_in = ST_NB_ADDR;
         end

         ST_NB_ADDR: begin
            cell_raddr = {nb_x, nb_y};
            if (nb_ok) begin
               state_in = ST_NB_DATA;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = (dir_ff == 2'd3) ? ST_POP : ST_NB_ADDR;
            end
         end

         // Colour, label and push an open neighbour
         ST_NB_DATA: begin
            cell_waddr = {nb_x, nb_y};
            stk_wdata  = {nb_x, nb_y};
            if (cell_open) begin
               cell_we = 1'b1;
               stk_we  = 1'b1;
               sp_in   = sp_ff + (AW + 1)'(1);
               cnt_in  = cnt_inc;
            end
            dir_in   = dir_ff + 2'd1;
            state_in = (dir_ff == 2'd3) ? ST_POP : ST_NB_ADDR;
         end

         ST_FIND_ADDR: begin
            state_in = ST_FIND_DATA;
         end

         // Scan x outer, y inner
         ST_FIND_DATA: begin
            if (cell_open) begin
               res_in.found   = 1'b1;
               res_in.found_x = 8'(x_ff);
               res_in.found_y = 8'(y_ff);
               state_in       = ST_RESP;
            end else if (y_next_ext < YCW'(gh_ff)) begin
               y_in     = y_ff + YW'(1);
               state_in = ST_FIND_ADDR;
            end else if (x_next_ext < XCW'(gw_ff)) begin
               x_in     = x_ff + XW'(1);
               y_in     = '0;
               state_in = ST_FIND_ADDR;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            cnt_in     = '0;
            clr_rsp_in = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration registers with clamping
   always_comb begin
      gw_in = gw_ff;
      gh_in = gh_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               if (csr_wdata == '0) begin
                  gw_in = GWW'(1);
               end else if (32'(csr_wdata) > MAX_WIDTH) begin
                  gw_in = GWW'(MAX_WIDTH);
               end else begin
                  gw_in = GWW'(csr_wdata);
               end
            end
            CSR_GRID_HEIGHT: begin
               if (csr_wdata == '0) begin
                  gh_in = GHW'(1);
               end else if (32'(csr_wdata) > MAX_HEIGHT) begin
                  gh_in = GHW'(MAX_HEIGHT);
               end else begin
                  gh_in = GHW'(csr_wdata);
               end
            end
            default: begin
               gw_in = gw_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         sp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gw_ff        <= GWW'(GW_RST);
         gh_ff        <= GHW'(GH_RST);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         sp_ff        <= sp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      bar_ff <= bar_in;
      lab_ff <= lab_in;
      dir_ff <= dir_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_cell_colored = out_ff.cell_colored;
   assign rsp_cell_barrier = out_ff.cell_barrier;
   assign rsp_cell_label   = out_ff.cell_label;
   assign rsp_found        = out_ff.found;
   assign rsp_found_x      = out_ff.found_x;
   assign rsp_found_y      = out_ff.found_y;
   assign rsp_cells_filled = out_ff.cells_filled;

endmodule

>>> src/gffl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gffl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/gffl_checker.sv
// Port-level checks for the flood-fill labeler, bound to the top level.
module gffl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic        rsp_cell_colored,
   input logic signed [15:0] rsp_cell_label,
   input logic        rsp_found,
   input logic [7:0]  rsp_found_x,
   input logic [7:0]  rsp_found_y,
   input logic [16:0] rsp_cells_filled
);

   // A waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A rejected coordinate carries no other result
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_cells_filled == 17'd0 && !rsp_found && !rsp_cell_colored)
      else $error("out-of-grid result carries data");

   // No location without a find hit
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_x == 8'd0 && rsp_found_y == 8'd0)
      else $error("location without find hit");

   // An uncoloured cell reads label zero
   a_label_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_colored |-> rsp_cell_label == 16'sd0)
      else $error("label on uncoloured cell");

   // Fill count and find hit never share a result
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_cells_filled == 17'd0 && !rsp_status)
      else $error("mixed result kinds");

endmodule

bind grid_flood_fill_labeler_core gffl_checker u_gffl_checker (.*);
